### rtl/lpr_pkg.sv
// Shared types, constants and helpers for the lattice polymer reptation block.
package lpr_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int COORD_BITS   = 16;

  localparam int ADDR_W     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W      = $clog2(MAX_SEGMENTS + 1);
  localparam int ABS_W      = COORD_BITS + 1;
  localparam int R2_W       = 2 * ABS_W;
  localparam int COIL_DIR_W = 8;
  localparam int COIL_TOT_W = 12;
  localparam int SHAPE_W    = 2;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int RAND_W     = 16;

  localparam int IN_FIELDS_W   = 1 + RAND_W + 1;
  localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = R2_W + CNT_W + 2 * COORD_BITS;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SHAPE_W-1:0] SH_LINE  = 2'd0;
  localparam logic [SHAPE_W-1:0] SH_STAIR = 2'd1;
  localparam logic [SHAPE_W-1:0] SH_COIL  = 2'd2;
  localparam logic [SHAPE_W-1:0] SH_SPARE = 2'd3;

  typedef enum logic [FUNC_W-1:0] {
    FN_START = 2'd0,
    FN_GROW  = 2'd1,
    FN_MOVE  = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BLOCKED = 2'd1,
    ST_SHORT   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DIR_E = 2'd0,
    DIR_N = 2'd1,
    DIR_W = 2'd2,
    DIR_S = 2'd3
  } dir_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } site_t;

  localparam int SITE_W = $bits(site_t);

  function automatic site_t neighbour(site_t s, dir_t d);
    site_t r;
    r = s;
    unique case (d)
      DIR_E: r.x = s.x + 1'b1;
      DIR_N: r.y = s.y + 1'b1;
      DIR_W: r.x = s.x - 1'b1;
      DIR_S: r.y = s.y - 1'b1;
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_add(logic [ADDR_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= (CNT_W + 1)'(MAX_SEGMENTS)) begin
      s = s - (CNT_W + 1)'(MAX_SEGMENTS);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

### rtl/lpr_store.sv
// Segment ring store: one write port, one registered read port.
module lpr_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [lpr_pkg::ADDR_W-1:0]  waddr,
  input  lpr_pkg::site_t              wdata,
  input  logic [lpr_pkg::ADDR_W-1:0]  raddr,
  output lpr_pkg::site_t              rdata
);
  import lpr_pkg::*;

  site_t mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lpr_cand.sv
// Move target selection among the end's neighbours that differ from the neck.
module lpr_cand (
  input  lpr_pkg::site_t                head,
  input  lpr_pkg::site_t                neck,
  input  logic [lpr_pkg::RAND_W-1:0]    rand_fraction,
  output lpr_pkg::site_t                target
);
  import lpr_pkg::*;

  site_t                c [4];
  logic  [3:0]          ok;
  logic  [2:0]          k;
  logic  [RAND_W+2:0]   prod;
  logic  [2:0]          pick;
  logic  [2:0]          j;

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      c[d]  = neighbour(head, dir_t'(d));
      ok[d] = (c[d] != neck);
    end
    k    = 3'($countones(ok));
    prod = (RAND_W + 3)'(rand_fraction) * (RAND_W + 3)'(k);
    pick = prod[RAND_W+2:RAND_W];
    if (pick >= k) begin
      pick = k - 3'd1;
    end
    target = head;
    j      = 3'd0;
    for (int d = 0; d < 4; d++) begin
      if (ok[d]) begin
        if (j == pick) begin
          target = c[d];
        end
        j = j + 3'd1;
      end
    end
  end

endmodule

### rtl/lattice_polymer_reptation_step.sv
// Top level: sequencer, shared squaring unit and output register of the reptation step.
//
// Usage:
//   Items arrive on the s_axis channel; func travels in s_axis_tuser, the other
//   fields in s_axis_tdata. One result per item leaves on the m_axis channel,
//   status in m_axis_tuser. initial_shape is written on the cfg channel, which
//   is always ready.
//   Path from accept to m_axis_tvalid:
//     start, no-op and steps refused as too short or full go straight to squaring.
//     grow writes one store entry; the coil shape first checks and advances the spiral.
//     move reads both neck sites, picks a target and then runs the occupancy scan,
//     which reads the segment store one entry per cycle through its single read
//     port and compares each with the target site in one comparator.
//   One item is in work at a time; s_axis_tready is low from accept until the
//   result is loaded into the output register. A result waiting there does not
//   stop the next transaction from being accepted; a stalled receiver holds the
//   sequencer only when it has the next result ready.
//   Reset clears the chain length, pointers, coil state and the shape register;
//   the segment store needs no clearing.
module lattice_polymer_reptation_step (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] end_pick, [16:1] rand_fraction, [17] stair_pick, zero pad
  input  logic [lpr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] func
  input  logic [lpr_pkg::FUNC_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [33:0] end_to_end_sq, [40:34] chain_length, [56:41] front_x, [72:57] front_y
  output logic [lpr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [lpr_pkg::STATUS_W-1:0]       m_axis_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lpr_pkg::SHAPE_W-1:0]        cfg_data
);
  import lpr_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_COIL   = 12'b0000_0000_0010,
    S_GROW   = 12'b0000_0000_0100,
    S_RD1    = 12'b0000_0000_1000,
    S_RD2    = 12'b0000_0001_0000,
    S_RD3    = 12'b0000_0010_0000,
    S_CAND   = 12'b0000_0100_0000,
    S_SCAN   = 12'b0000_1000_0000,
    S_COMMIT = 12'b0001_0000_0000,
    S_SQX    = 12'b0010_0000_0000,
    S_SQY    = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t                 state;
  logic [ADDR_W-1:0]      fp;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       grow_idx;
  logic [COIL_DIR_W-1:0]  coil_dir;
  logic [COIL_TOT_W-1:0]  coil_tot;
  logic [SHAPE_W-1:0]     shape;
  logic                   rd_v;

  site_t                  front;
  site_t                  back;
  site_t                  seg1;
  site_t                  segn2;
  site_t                  nxt;
  logic                   end_l;
  logic [RAND_W-1:0]      rnd_l;
  logic                   stair_l;
  logic                   hit;
  logic [CNT_W-1:0]       idx;
  status_t                status_r;
  logic [R2_W-1:0]        acc;

  logic                   s_acc;
  logic                   out_free;
  func_t                  func_in;
  logic [ADDR_W-1:0]      fp_dec;
  logic [CNT_W-1:0]       step;
  logic [COIL_DIR_W-1:0]  coil_dir_inc;
  dir_t                   grow_dir;
  site_t                  grow_site;
  site_t                  cand_site;
  site_t                  head;
  site_t                  neck;
  logic [ABS_W-1:0]       dx;
  logic [ABS_W-1:0]       dy;
  logic [ABS_W-1:0]       ax;
  logic [ABS_W-1:0]       ay;
  logic [ABS_W-1:0]       mul_a;
  logic [R2_W-1:0]        prod;

  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  site_t                  wdata;
  logic [ADDR_W-1:0]      raddr;
  site_t                  rdata;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign func_in       = func_t'(s_axis_tuser);

  assign fp_dec       = (fp == '0) ? ADDR_W'(MAX_SEGMENTS - 1) : fp - 1'b1;
  assign step         = grow_idx + 1'b1;
  assign coil_dir_inc = coil_dir + 1'b1;

  always_comb begin
    priority if (shape == SH_STAIR) begin
      grow_dir = stair_l ? DIR_N : DIR_E;
    end else if (shape == SH_COIL) begin
      grow_dir = dir_t'(coil_dir[1:0] + 2'd2);
    end else begin
      grow_dir = DIR_E;
    end
  end

  assign grow_site = neighbour(front, grow_dir);
  assign head      = end_l ? back : front;
  assign neck      = end_l ? segn2 : seg1;

  lpr_cand u_cand (
    .head          (head),
    .neck          (neck),
    .rand_fraction (rnd_l),
    .target        (cand_site)
  );

  assign dx    = {front.x[COORD_BITS-1], front.x} - {back.x[COORD_BITS-1], back.x};
  assign dy    = {front.y[COORD_BITS-1], front.y} - {back.y[COORD_BITS-1], back.y};
  assign ax    = dx[ABS_W-1] ? -dx : dx;
  assign ay    = dy[ABS_W-1] ? -dy : dy;
  assign mul_a = (state == S_SQY) ? ay : ax;
  assign prod  = R2_W'(mul_a) * R2_W'(mul_a);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = nxt;
    raddr = '0;
    if (s_acc && func_in == FN_START) begin
      we    = 1'b1;
      waddr = '0;
      wdata = '0;
    end
    if (state == S_GROW) begin
      we    = 1'b1;
      waddr = fp_dec;
      wdata = grow_site;
    end
    if (state == S_COMMIT && !hit) begin
      we    = 1'b1;
      waddr = end_l ? slot_add(fp, count) : fp_dec;
      wdata = nxt;
    end
    if (state == S_RD1) begin
      raddr = slot_add(fp, CNT_W'(1));
    end
    if (state == S_RD2) begin
      raddr = slot_add(fp, count - CNT_W'(2));
    end
    if (state == S_SCAN) begin
      raddr = slot_add(fp, idx);
    end
  end

  lpr_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      shape <= SH_LINE;
    end else if (cfg_valid && cfg_ready) begin
      shape <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fp       <= '0;
      count    <= '0;
      grow_idx <= '0;
      coil_dir <= '0;
      coil_tot <= '0;
      rd_v     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            end_l    <= s_axis_tdata[0];
            rnd_l    <= s_axis_tdata[RAND_W:1];
            stair_l  <= s_axis_tdata[RAND_W+1];
            unique case (func_in)
              FN_START: begin
                status_r <= ST_OK;
                fp       <= '0;
                count    <= CNT_W'(1);
                grow_idx <= '0;
                coil_dir <= '0;
                coil_tot <= '0;
                front    <= '0;
                back     <= '0;
                state    <= S_SQX;
              end
              FN_GROW: begin
                priority if (count == '0) begin
                  status_r <= ST_SHORT;
                  state    <= S_SQX;
                end else if (count >= CNT_W'(MAX_SEGMENTS)) begin
                  status_r <= ST_FULL;
                  state    <= S_SQX;
                end else begin
                  status_r <= ST_OK;
                  state    <= (shape == SH_COIL) ? S_COIL : S_GROW;
                end
              end
              FN_MOVE: begin
                if (count < CNT_W'(2)) begin
                  status_r <= ST_SHORT;
                  state    <= S_SQX;
                end else begin
                  status_r <= ST_OK;
                  state    <= S_RD1;
                end
              end
              FN_NOP: begin
                status_r <= ST_OK;
                state    <= S_SQX;
              end
              default: begin
                status_r <= ST_OK;
                state    <= S_SQX;
              end
            endcase
          end
        end
        S_COIL: begin
          if (coil_tot < COIL_TOT_W'(step)) begin
            coil_dir <= coil_dir_inc;
            coil_tot <= coil_tot + COIL_TOT_W'(coil_dir_inc >> 1);
          end else begin
            state <= S_GROW;
          end
        end
        S_GROW: begin
          fp       <= fp_dec;
          front    <= grow_site;
          count    <= count + 1'b1;
          grow_idx <= grow_idx + 1'b1;
          state    <= S_SQX;
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          seg1  <= rdata;
          state <= S_RD3;
        end
        S_RD3: begin
          segn2 <= rdata;
          state <= S_CAND;
        end
        S_CAND: begin
          nxt   <= cand_site;
          idx   <= '0;
          hit   <= 1'b0;
          rd_v  <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (idx < count) begin
            idx  <= idx + 1'b1;
            rd_v <= 1'b1;
          end else begin
            rd_v <= 1'b0;
          end
          if (rd_v && rdata == nxt) begin
            hit <= 1'b1;
          end
          if (idx == count && !rd_v) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          priority if (hit) begin
            status_r <= ST_BLOCKED;
          end else if (!end_l) begin
            fp    <= fp_dec;
            front <= nxt;
            back  <= segn2;
          end else begin
            fp    <= slot_add(fp, CNT_W'(1));
            back  <= nxt;
            front <= seg1;
          end
          state <= S_SQX;
        end
        S_SQX: begin
          acc   <= prod;
          state <= S_SQY;
        end
        S_SQY: begin
          acc   <= acc + prod;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_axis_tuser <= status_r;
      m_axis_tdata <= OUT_DATA_W'({
        (count != '0) ? front.y : {COORD_BITS{1'b0}},
        (count != '0) ? front.x : {COORD_BITS{1'b0}},
        count,
        (count >= CNT_W'(2)) ? acc : {R2_W{1'b0}}
      });
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SEGMENTS))
    else $error("chain length beyond store depth");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (s_acc && func_in == FN_START) |=> (count == CNT_W'(1) && fp == '0))
    else $error("start transaction did not reset the chain");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_IDLE || state == S_GROW || state == S_COMMIT))
    else $error("store write outside start, grow or commit");

  a_blocked_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && hit) |=> ($stable(fp) && status_r == ST_BLOCKED))
    else $error("blocked move changed the chain");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the lattice polymer reptation step block.
`timescale 1ns / 1ps

module tb_top;
  import lpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int DRAIN_CYCLES   = 100;

  typedef struct {
    func_t           fn;
    logic            end_pick;
    logic [RAND_W-1:0] frac;
    logic            stair;
  } chain_cmd_t;

  typedef struct {
    status_t               st;
    logic [R2_W-1:0]       r2;
    logic [CNT_W-1:0]      len;
    logic [COORD_BITS-1:0] fx;
    logic [COORD_BITS-1:0] fy;
  } chain_report_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_W-1:0]      s_axis_tdata = '0;
  logic [FUNC_W-1:0]         s_axis_tuser = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]     m_axis_tdata;
  logic [STATUS_W-1:0]       m_axis_tuser;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [SHAPE_W-1:0]        cfg_data = '0;

  lattice_polymer_reptation_step u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // chain predictor state
  site_t              chain_mem [MAX_SEGMENTS];
  int                 head_ptr;
  int                 seg_total;
  int                 grow_steps;
  int                 coil_dir;
  int                 coil_sum;
  logic [SHAPE_W-1:0] shape_reg;

  chain_cmd_t    cmd_backlog[$];
  chain_report_t expected_reports[$];
  chain_cmd_t    cur_cmd;
  logic          cmd_held = 1'b0;
  int            send_gap = 0;
  int            calm_s = 0;
  int            calm_m = 0;
  int            stall_left = 0;
  int            queued = 0;
  int            errors = 0;
  int            shape_writes = 0;
  int            func_cnt [4];
  int            status_cnt [4];
  int            idle_cycles = 0;

  function automatic site_t step_site(site_t s, dir_t d);
    site_t r;
    r = s;
    case (d)
      DIR_E: r.x = s.x + 1'b1;
      DIR_N: r.y = s.y + 1'b1;
      DIR_W: r.x = s.x - 1'b1;
      default: r.y = s.y - 1'b1;
    endcase
    return r;
  endfunction

  function automatic site_t chain_at(int k);
    return chain_mem[(head_ptr + k) % MAX_SEGMENTS];
  endfunction

  function automatic void put_front(site_t s);
    head_ptr = (head_ptr + MAX_SEGMENTS - 1) % MAX_SEGMENTS;
    chain_mem[head_ptr] = s;
  endfunction

  function automatic chain_report_t reptate(chain_cmd_t c);
    chain_report_t rep;
    site_t         head, neck, nxt, f, b;
    site_t         cand [4];
    dir_t          d;
    int            k, pick, target;
    logic          occupied;
    longint        dx, dy;
    rep.st = ST_OK;
    case (c.fn)
      FN_START: begin
        head_ptr = 0;
        chain_mem[0] = '0;
        seg_total = 1;
        grow_steps = 0;
        coil_dir = 0;
        coil_sum = 0;
      end
      FN_GROW: begin
        if (seg_total == 0) begin
          rep.st = ST_SHORT;
        end else if (seg_total >= MAX_SEGMENTS) begin
          rep.st = ST_FULL;
        end else begin
          target = grow_steps + 1;
          if (shape_reg == SH_STAIR) begin
            d = c.stair ? DIR_N : DIR_E;
          end else if (shape_reg == SH_COIL) begin
            while (coil_sum < target) begin
              coil_dir++;
              coil_sum += coil_dir / 2;
            end
            d = dir_t'((coil_dir + 2) % 4);
          end else begin
            d = DIR_E;
          end
          put_front(step_site(chain_at(0), d));
          seg_total++;
          grow_steps++;
        end
      end
      FN_MOVE: begin
        if (seg_total < 2) begin
          rep.st = ST_SHORT;
        end else begin
          if (!c.end_pick) begin
            head = chain_at(0);
            neck = chain_at(1);
          end else begin
            head = chain_at(seg_total - 1);
            neck = chain_at(seg_total - 2);
          end
          k = 0;
          for (int i = 0; i < 4; i++) begin
            nxt = step_site(head, dir_t'(i));
            if (nxt !== neck) begin
              cand[k] = nxt;
              k++;
            end
          end
          pick = (int'(c.frac) * k) >> 16;
          if (pick >= k) pick = k - 1;
          nxt = cand[pick];
          occupied = 1'b0;
          for (int i = 0; i < seg_total; i++) begin
            if (chain_at(i) == nxt) occupied = 1'b1;
          end
          if (occupied) begin
            rep.st = ST_BLOCKED;
          end else if (!c.end_pick) begin
            put_front(nxt);
          end else begin
            head_ptr = (head_ptr + 1) % MAX_SEGMENTS;
            chain_mem[(head_ptr + seg_total - 1) % MAX_SEGMENTS] = nxt;
          end
        end
      end
      default: ;
    endcase
    rep.r2 = '0;
    rep.fx = '0;
    rep.fy = '0;
    if (seg_total >= 1) begin
      f = chain_at(0);
      rep.fx = f.x;
      rep.fy = f.y;
    end
    if (seg_total >= 2) begin
      f = chain_at(0);
      b = chain_at(seg_total - 1);
      dx = longint'($signed(f.x)) - longint'($signed(b.x));
      dy = longint'($signed(f.y)) - longint'($signed(b.y));
      rep.r2 = R2_W'(dx * dx + dy * dy);
    end
    rep.len = CNT_W'(seg_total);
    func_cnt[c.fn]++;
    status_cnt[rep.st]++;
    return rep;
  endfunction

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [RAND_W-1:0] rand_frac();
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 5))
        0: return 16'h0000;
        1: return 16'hFFFF;
        2: return 16'd21845;
        3: return 16'd21846;
        4: return 16'd43690;
        default: return 16'd43691;
      endcase
    end
    return RAND_W'($urandom_range(0, 65535));
  endfunction

  task automatic add_cmd(func_t f, logic ep, logic [RAND_W-1:0] fr, logic st);
    chain_cmd_t c;
    c.fn = f;
    c.end_pick = ep;
    c.frac = fr;
    c.stair = st;
    cmd_backlog.insert(cmd_backlog.size(), c);
    queued++;
  endtask

  task automatic add_rand_cmd(func_t f);
    add_cmd(f, 1'($urandom_range(0, 1)), rand_frac(), 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || cmd_held || expected_reports.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_shape(logic [SHAPE_W-1:0] v);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shape_reg = v;
    shape_writes++;
  endtask

  task automatic add_episode();
    int r, n_grow, n_move;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) add_rand_cmd(func_t'($urandom_range(0, 3)));
      return;
    end
    if (r >= 20 || $urandom_range(0, 3) != 0) add_rand_cmd(FN_START);
    n_grow = (r < 20) ? $urandom_range(60, 68) : $urandom_range(1, 16);
    n_move = $urandom_range(4, 40);
    repeat (n_grow) add_rand_cmd(FN_GROW);
    repeat (n_move) begin
      case ($urandom_range(0, 19))
        0: add_rand_cmd(FN_GROW);
        1: add_rand_cmd(FN_NOP);
        default: add_rand_cmd(FN_MOVE);
      endcase
    end
  endtask

  // driver
  always @(posedge clk) begin
    chain_report_t rep;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rep = reptate(cur_cmd);
        expected_reports.insert(expected_reports.size(), rep);
        cmd_held = 1'b0;
        send_gap = idle_len(calm_s);
      end
      if (cmd_held) begin
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        cur_cmd = cmd_backlog[0];
        cmd_backlog.delete(0);
        cmd_held = 1'b1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'({cur_cmd.stair, cur_cmd.frac, cur_cmd.end_pick});
        s_axis_tuser <= cur_cmd.fn;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    chain_report_t         want;
    logic [R2_W-1:0]       got_r2;
    logic [CNT_W-1:0]      got_len;
    logic [COORD_BITS-1:0] got_fx, got_fy;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_r2  = m_axis_tdata[R2_W-1:0];
      got_len = m_axis_tdata[R2_W +: CNT_W];
      got_fx  = m_axis_tdata[R2_W + CNT_W +: COORD_BITS];
      got_fy  = m_axis_tdata[R2_W + CNT_W + COORD_BITS +: COORD_BITS];
      if (expected_reports.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        want = expected_reports[0];
        expected_reports.delete(0);
        if (m_axis_tuser !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, m_axis_tuser);
          errors++;
        end
        if (got_r2 !== want.r2) begin
          $error("end_to_end_sq: expected %0d, got %0d", want.r2, got_r2);
          errors++;
        end
        if (got_len !== want.len) begin
          $error("chain_length: expected %0d, got %0d", want.len, got_len);
          errors++;
        end
        if (got_fx !== want.fx) begin
          $error("front_x: expected %0d, got %0d", $signed(want.fx), $signed(got_fx));
          errors++;
        end
        if (got_fy !== want.fy) begin
          $error("front_y: expected %0d, got %0d", $signed(want.fy), $signed(got_fy));
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = idle_len(calm_m);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("** lattice_polymer_reptation_step: FAILED **");
      $finish;
    end
  end

  initial begin
    int directed;
    int phase;
    int phase_start;
    head_ptr = 0;
    seg_total = 0;
    grow_steps = 0;
    coil_dir = 0;
    coil_sum = 0;
    shape_reg = SH_LINE;
    foreach (chain_mem[i]) chain_mem[i] = '0;
    foreach (func_cnt[i]) func_cnt[i] = 0;
    foreach (status_cnt[i]) status_cnt[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // line shape: empty chain, single segment, a short line
    write_shape(SH_LINE);
    add_cmd(FN_GROW, 1'b0, 16'h0000, 1'b0);
    add_cmd(FN_MOVE, 1'b1, 16'hFFFF, 1'b1);
    add_cmd(FN_NOP, 1'b1, 16'hFFFF, 1'b1);
    add_cmd(FN_START, 1'b0, 16'h0000, 1'b0);
    add_cmd(FN_MOVE, 1'b0, 16'h8000, 1'b0);
    add_cmd(FN_GROW, 1'b0, 16'h0000, 1'b1);
    add_cmd(FN_GROW, 1'b1, 16'hFFFF, 1'b1);
    add_cmd(FN_GROW, 1'b0, 16'h5555, 1'b0);
    add_cmd(FN_MOVE, 1'b0, 16'h0000, 1'b0);
    add_cmd(FN_MOVE, 1'b1, 16'hFFFF, 1'b1);
    add_cmd(FN_NOP, 1'b0, 16'h0000, 1'b0);
    add_cmd(FN_START, 1'b1, 16'hFFFF, 1'b1);

    // coil shape: back end blocked by front, front blocked by the tail, then by the tail again
    write_shape(SH_COIL);
    add_cmd(FN_START, 1'b0, 16'h0000, 1'b0);
    repeat (3) add_cmd(FN_GROW, 1'b0, 16'h0000, 1'b0);
    add_cmd(FN_MOVE, 1'b1, 16'h0000, 1'b0);
    add_cmd(FN_MOVE, 1'b0, 16'hFFFF, 1'b0);
    repeat (2) add_cmd(FN_GROW, 1'b0, 16'h0000, 1'b0);
    add_cmd(FN_MOVE, 1'b0, 16'h0000, 1'b0);

    // stair shape: both growth directions
    write_shape(SH_STAIR);
    add_cmd(FN_START, 1'b0, 16'h0000, 1'b0);
    add_cmd(FN_GROW, 1'b0, 16'h2AAA, 1'b0);
    add_cmd(FN_GROW, 1'b1, 16'hD555, 1'b1);
    directed = queued;

    phase = 0;
    while (queued < directed + RANDOM_ITEMS) begin
      case (phase)
        0: write_shape(SH_COIL);
        1: write_shape(SH_LINE);
        2: write_shape(SH_SPARE);
        3: write_shape(SH_STAIR);
        default: write_shape(SHAPE_W'($urandom_range(0, 3)));
      endcase
      phase_start = queued;
      while (queued - phase_start < 150 && queued < directed + RANDOM_ITEMS) begin
        add_episode();
      end
      phase++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d items (start %0d, grow %0d, move %0d, no-op %0d), %0d shape writes",
             queued, func_cnt[FN_START], func_cnt[FN_GROW], func_cnt[FN_MOVE],
             func_cnt[FN_NOP], shape_writes);
    $display("status seen: ok %0d, blocked %0d, too short %0d, full %0d; %0d mismatches",
             status_cnt[ST_OK], status_cnt[ST_BLOCKED], status_cnt[ST_SHORT],
             status_cnt[ST_FULL], errors);
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("** lattice_polymer_reptation_step: PASSED **");
    end else begin
      $display("** lattice_polymer_reptation_step: FAILED **");
    end
    $finish;
  end

endmodule
